FILE: rtl/packed_glyph_pixel_unpacker_unit_macros.svh
// ----------------------------------------------------------------------------
// packed glyph pixel unpacker assertion macros
// shared concurrent assertion forms, same-cycle and next-cycle implication
// ----------------------------------------------------------------------------
`ifndef PACKED_GLYPH_PIXEL_UNPACKER_UNIT_MACROS_SVH
`define PACKED_GLYPH_PIXEL_UNPACKER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PGPU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PGPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pgpu_pkg.sv
// ----------------------------------------------------------------------------
// pgpu_pkg
// constants and helper functions for the packed glyph pixel unpacker
// ----------------------------------------------------------------------------
package pgpu_pkg;

  localparam int MAX_GLYPH_SIDE_DEFAULT = 255;

  localparam int DEPTH_W = 4;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_BITS_PER_PIXEL = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN_THREE    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_WIDTH    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_HEIGHT   = 8'd3;

  localparam logic [DEPTH_W-1:0] BPP_RESET = 4'd4;

  // floor(2^16 / (2^d - 1)) for the reciprocal divide
  localparam logic [16:0] RECIP_1 = 17'(65536 / 1);
  localparam logic [16:0] RECIP_2 = 17'(65536 / 3);
  localparam logic [16:0] RECIP_3 = 17'(65536 / 7);
  localparam logic [16:0] RECIP_4 = 17'(65536 / 15);
  localparam logic [16:0] RECIP_5 = 17'(65536 / 31);
  localparam logic [16:0] RECIP_6 = 17'(65536 / 63);
  localparam logic [16:0] RECIP_7 = 17'(65536 / 127);
  localparam logic [16:0] RECIP_8 = 17'(65536 / 255);

  function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] bpp);
    logic [DEPTH_W-1:0] d;
    if (bpp == 4'd0) begin
      d = 4'd1;
    end else if (bpp > 4'd8) begin
      d = 4'd8;
    end else begin
      d = bpp;
    end
    return d;
  endfunction

  // low n bits set, n from 0 to 8
  function automatic logic [7:0] low_mask8(input logic [DEPTH_W-1:0] n);
    logic [15:0] m;
    m = (16'd1 << n) - 16'd1;
    return m[7:0];
  endfunction

  // low n bits set, n from 0 to 15
  function automatic logic [14:0] low_mask15(input logic [DEPTH_W-1:0] n);
    logic [15:0] m;
    m = (16'd1 << n) - 16'd1;
    return m[14:0];
  endfunction

  function automatic logic [16:0] recip_of(input logic [DEPTH_W-1:0] depth);
    logic [16:0] r;
    case (depth)
      4'd1:    r = RECIP_1;
      4'd2:    r = RECIP_2;
      4'd3:    r = RECIP_3;
      4'd4:    r = RECIP_4;
      4'd5:    r = RECIP_5;
      4'd6:    r = RECIP_6;
      4'd7:    r = RECIP_7;
      default: r = RECIP_8;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/packed_glyph_pixel_unpacker_unit.sv
// ----------------------------------------------------------------------------
// packed_glyph_pixel_unpacker_unit
// unpacks an msb-first packed glyph bitmap, one byte per request, into gray
// pixels with their column and row
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------
//  in       | in  | in_valid / in_stall    | bitmap_byte, first_byte, last_byte
//  out      | out | out_valid / out_stall  | pixel_gray, pixel_column, pixel_row,
//           |     |                        | last_of_run, glyph_complete
//  cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  each pixel of a request passes through the slot step, with the shared
//  reciprocal multiply, and then the correct step, one pixel at a time; the next
//  byte waits until the unit is idle; a byte ignored after the end of a glyph
//  leaves the unit idle, any other byte that yields no pixel visits the slot step only
//  rst is synchronous and active high; no clearing pass is needed
//  out_stall holds the pixel in the output register; the sequencer waits in
//  its correct step until the register frees up
//  cfg_ready is always high; the user must write registers only while idle, the block does not enforce it
//
module packed_glyph_pixel_unpacker_unit #(
  parameter int MAX_GLYPH_SIDE = pgpu_pkg::MAX_GLYPH_SIDE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // input bytes
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       bitmap_byte,
  input  logic                             first_byte,
  input  logic                             last_byte,
  // pixel results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       pixel_gray,
  output logic [7:0]                       pixel_column,
  output logic [7:0]                       pixel_row,
  output logic                             last_of_run,
  output logic                             glyph_complete,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pgpu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pgpu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // position counters only need to hold values up to the clamped side
  localparam int PosW = (MAX_GLYPH_SIDE >= 255) ? 8 : $clog2(MAX_GLYPH_SIDE + 1);
  localparam logic [16:0] MaxSide17 = 17'(MAX_GLYPH_SIDE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SLOT = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0] state;

  // configuration registers
  logic [3:0] bits_per_pixel;
  logic       align_three_to_four;
  logic [7:0] glyph_width;
  logic [7:0] glyph_height;

  // glyph state
  logic [6:0]      leftover_bits;
  logic [2:0]      leftover_count;
  logic [PosW-1:0] current_column;
  logic [PosW-1:0] current_row;
  logic            all_pixels_done;

  // per-request work registers
  logic [14:0] acc;
  logic [3:0]  cnt;
  logic        last_flag;
  logic        tail_done;

  // multiply stage to correct stage
  logic [32:0]     prod;
  logic [15:0]     prod_p;
  logic [PosW-1:0] em_column;
  logic [PosW-1:0] em_row;
  logic            em_last;
  logic            em_complete;

  // ---------------------------------------------------------------- decode
  logic [3:0]      depth;
  logic [3:0]      rd;
  logic [7:0]      maxv;
  logic [PosW-1:0] w_c;
  logic [PosW-1:0] h_c;

  always_comb begin
    depth = pgpu_pkg::clamp_depth(bits_per_pixel);
    // depth 3 with alignment reads a 4-bit slot
    rd    = (depth == 4'd3 && align_three_to_four) ? 4'd4 : depth;
    maxv  = pgpu_pkg::low_mask8(depth);
    w_c   = ({9'd0, glyph_width} > MaxSide17) ? PosW'(MAX_GLYPH_SIDE) : PosW'(glyph_width);
    h_c   = ({9'd0, glyph_height} > MaxSide17) ? PosW'(MAX_GLYPH_SIDE) : PosW'(glyph_height);
  end

  // ---------------------------------------------------------------- slot step
  logic            have_full;
  logic            have_tail;
  logic            slot;
  logic            eligible;
  logic [3:0]      cnt_after;
  logic [14:0]     cnt_mask;
  logic [14:0]     full_shift;
  logic [14:0]     tail_shift;
  logic [7:0]      pix_v;
  logic [15:0]     pix_p;
  logic [32:0]     pix_prod;
  logic [PosW-1:0] col_use;
  logic [PosW-1:0] col_inc;
  logic [PosW-1:0] row_inc;
  logic            col_wrap;
  logic            complete;
  logic            more_slot;
  logic            run_end;

  always_comb begin
    have_full  = (cnt >= rd);
    // on the last byte a partial pixel is padded with zero bits
    have_tail  = !have_full && last_flag && (cnt != 4'd0) && !tail_done;
    slot       = have_full || have_tail;
    eligible   = !all_pixels_done && (w_c != '0) && (h_c != '0) && (current_row < h_c);
    cnt_after  = have_full ? (cnt - rd) : cnt;
    cnt_mask   = pgpu_pkg::low_mask15(cnt);
    full_shift = (acc >> cnt_after) & pgpu_pkg::low_mask15(rd);
    tail_shift = (acc & cnt_mask) << (rd - cnt);
    pix_v      = (have_full ? full_shift[7:0] : tail_shift[7:0]) & maxv;
    pix_p      = {pix_v, 8'd0} - {8'd0, pix_v};
    pix_prod   = {17'd0, pix_p} * {16'd0, pgpu_pkg::recip_of(depth)};
    // column wraps when it has reached a width that shrank
    col_use    = (current_column >= w_c) ? '0 : current_column;
    col_inc    = PosW'(col_use + 1'b1);
    row_inc    = PosW'(current_row + 1'b1);
    col_wrap   = (col_inc >= w_c);
    complete   = col_wrap && (row_inc >= h_c);
    more_slot  = (cnt_after >= rd) || (last_flag && !have_tail && (cnt_after != 4'd0));
    run_end    = complete || !more_slot;
  end

  // ---------------------------------------------------------------- correct step
  logic [7:0]  q_est;
  logic [15:0] q_back;
  logic [15:0] q_rem;
  logic [7:0]  q_fix;
  logic        load_ok;

  always_comb begin
    q_est   = prod[23:16];
    q_back  = {8'd0, q_est} * {8'd0, maxv};
    q_rem   = prod_p - q_back;
    // estimate is exact or one low
    q_fix   = (q_rem >= {8'd0, maxv}) ? 8'(q_est + 1'b1) : q_est;
    load_ok = !out_valid || !out_stall;
  end

  // ---------------------------------------------------------------- accept
  logic in_accept;
  logic done_c;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign done_c    = first_byte ? 1'b0 : all_pixels_done;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      bits_per_pixel      <= pgpu_pkg::BPP_RESET;
      align_three_to_four <= 1'b0;
      glyph_width         <= '0;
      glyph_height        <= '0;
      leftover_bits       <= '0;
      leftover_count      <= '0;
      current_column      <= '0;
      current_row         <= '0;
      all_pixels_done     <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      // config write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pgpu_pkg::CFG_BITS_PER_PIXEL: bits_per_pixel      <= cfg_data[3:0];
          pgpu_pkg::CFG_ALIGN_THREE:    align_three_to_four <= cfg_data[0];
          pgpu_pkg::CFG_GLYPH_WIDTH:    glyph_width         <= cfg_data;
          pgpu_pkg::CFG_GLYPH_HEIGHT:   glyph_height        <= cfg_data;
          default: ;
        endcase
      end

      // output register loads from the correct step, drains when its pixel is taken
      if (state == ST_FIX && load_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (first_byte) begin
              leftover_bits   <= '0;
              leftover_count  <= '0;
              current_column  <= '0;
              current_row     <= '0;
              all_pixels_done <= 1'b0;
            end
            // a finished glyph ignores bytes until the next first byte
            if (!done_c) begin
              state <= ST_SLOT;
            end
          end
        end

        ST_SLOT: begin
          if (slot && eligible) begin
            em_column <= col_use;
            em_row    <= current_row;
            em_last   <= run_end;
            em_complete <= complete;
            if (col_wrap) begin
              current_column <= '0;
              current_row    <= row_inc;
            end else begin
              current_column <= col_inc;
            end
            if (complete) begin
              all_pixels_done <= 1'b1;
            end
            state <= ST_FIX;
          end else begin
            // byte used up, or glyph ended: settle leftover bits
            if (all_pixels_done || slot || last_flag) begin
              leftover_bits  <= '0;
              leftover_count <= '0;
            end else begin
              leftover_bits  <= acc[6:0] & cnt_mask[6:0];
              leftover_count <= cnt[2:0];
            end
            if (slot || last_flag) begin
              all_pixels_done <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end

        ST_FIX: begin
          if (load_ok) begin
            state <= ST_SLOT;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      acc       <= {(first_byte ? 7'd0 : leftover_bits), bitmap_byte};
      cnt       <= {1'b0, (first_byte ? 3'd0 : leftover_count)} + 4'd8;
      last_flag <= last_byte;
      tail_done <= 1'b0;
    end
    if (state == ST_SLOT && slot && eligible) begin
      cnt       <= cnt_after;
      tail_done <= tail_done || have_tail;
    end
    if (state == ST_SLOT) begin
      prod   <= pix_prod;
      prod_p <= pix_p;
    end
    if (state == ST_FIX && load_ok) begin
      pixel_gray     <= ~q_fix;
      pixel_column   <= 8'(em_column);
      pixel_row      <= 8'(em_row);
      last_of_run    <= em_last;
      glyph_complete <= em_complete;
    end
  end

  // ---------------------------------------------------------------- checks
`include "packed_glyph_pixel_unpacker_unit_macros.svh"

  `PGPU_ASSERT_NOW(a_complete_ends_run, clk, rst, out_valid && glyph_complete,
                   last_of_run, "glyph end not flagged as end of run")
  `PGPU_ASSERT_NOW(a_done_no_leftover, clk, rst, state == ST_IDLE && all_pixels_done,
                   leftover_count == 3'd0, "leftover bits kept after glyph end")
  `PGPU_ASSERT_NEXT(a_fix_loads_out, clk, rst, state == ST_FIX && load_ok,
                    out_valid && state == ST_SLOT, "pixel not loaded into output register")
  `PGPU_ASSERT_NEXT(a_fix_waits, clk, rst, state == ST_FIX && !load_ok,
                    state == ST_FIX, "correct step left while output blocked")

endmodule
